[rtl/core/pth_sensor_compensation_defines.svh]
// assertion helpers shared by the compensation core
`ifndef PTH_SENSOR_COMPENSATION_DEFINES_SVH
`define PTH_SENSOR_COMPENSATION_DEFINES_SVH

// condition must hold at every edge out of reset
`define PTH_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// when pre holds, post must hold in the next cycle
`define PTH_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[rtl/core/pth_pkg.sv]
`default_nettype none
package pth_pkg;
  typedef logic signed [31:0] word_t;
  typedef logic [2:0] cfg_index_t;

  localparam cfg_index_t CFG_TEMP      = 3'd0;
  localparam cfg_index_t CFG_PRESS_LOW = 3'd1;
  localparam cfg_index_t CFG_PRESS_HI  = 3'd2;
  localparam cfg_index_t CFG_PRESS_P9  = 3'd3;
  localparam cfg_index_t CFG_HUM       = 3'd4;

  localparam word_t HUM_MAX = 32'sd419430400;

  // side data that rides along with the divider
  typedef struct packed {
    word_t       temp;
    logic [16:0] hum;
    logic        div_zero;
    logic        num_small;
  } side_t;
endpackage
`default_nettype wire

[rtl/core/pth_div.sv]
`default_nettype none
// pipelined restoring divider, one quotient bit per stage
module pth_div #(
  parameter int W      = 32,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [W-1:0]      dividend,
  input  wire logic [W-1:0]      divisor,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   out_valid,
  output logic [W-1:0]           quotient,
  output logic [SIDE_W-1:0]      side_out
);
  logic              vld  [W];
  logic [W-1:0]      rem  [W];
  logic [W-1:0]      num  [W];
  logic [W-1:0]      quo  [W];
  logic [W-1:0]      den  [W];
  logic [SIDE_W-1:0] side [W];

  for (genvar k = 0; k < W; k++) begin : g_st
    logic              vp;
    logic [W-1:0]      rp, np, qp, dp;
    logic [SIDE_W-1:0] sp;
    logic [W:0]        trial, diff;
    if (k == 0) begin : g_first
      assign vp = in_valid;
      assign rp = '0;
      assign np = dividend;
      assign qp = '0;
      assign dp = divisor;
      assign sp = side_in;
    end else begin : g_next
      assign vp = vld[k-1];
      assign rp = rem[k-1];
      assign np = num[k-1];
      assign qp = quo[k-1];
      assign dp = den[k-1];
      assign sp = side[k-1];
    end
    assign trial = {rp, np[W-1]};
    assign diff  = trial - {1'b0, dp};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vp;
      end
      if (en) begin
        rem[k]  <= diff[W] ? trial[W-1:0] : diff[W-1:0];
        num[k]  <= {np[W-2:0], 1'b0};
        quo[k]  <= {qp[W-2:0], ~diff[W]};
        den[k]  <= dp;
        side[k] <= sp;
      end
    end
  end

  assign out_valid = vld[W-1];
  assign quotient  = quo[W-1];
  assign side_out  = side[W-1];
endmodule
`default_nettype wire

[rtl/core/pth_sensor_compensation.sv]
`default_nettype none
// Integer compensation of one raw pressure / temperature / humidity triple.
// Input channel: in_valid with raw_pressure, raw_temperature, raw_humidity;
// a transfer happens on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid with pressure_pa, temperature_centi and
// humidity_q10; the receiver holds out_stall high to keep the result.
// Coefficients are written through cfg_we / cfg_index / cfg_data while the
// block is idle; indexes above 4 are ignored.
// Throughput is one triple per cycle while the output is not stalled.
// From input transfer to out_valid a triple passes 10 stages of
// fixed-point multiply/shift, a 32-stage pipelined restoring divider
// (one quotient bit per stage) and 3 stages of pressure refinement ending
// in the output register. The whole pipeline advances together; while the
// output register holds a result under stall, in_stall is high and nothing
// moves or is lost. Synchronous reset clears all valid bits and zeroes every coefficient.
module pth_sensor_compensation (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [19:0] raw_pressure,
  input  wire logic [19:0] raw_temperature,
  input  wire logic [15:0] raw_humidity,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      pressure_pa,
  output logic signed [31:0] temperature_centi,
  output logic [16:0]      humidity_q10,
  input  wire logic        cfg_we,
  input  wire pth_pkg::cfg_index_t cfg_index,
  input  wire logic [63:0] cfg_data
);
  import pth_pkg::*;

  `include "pth_sensor_compensation_defines.svh"

  localparam int PRE = 10;

  logic [47:0] temp_coeffs;
  logic [63:0] press_low, press_high, hum_coeffs;
  logic [15:0] press_nine;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs <= '0;
      press_low   <= '0;
      press_high  <= '0;
      press_nine  <= '0;
      hum_coeffs  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEMP:      temp_coeffs <= cfg_data[47:0];
        CFG_PRESS_LOW: press_low   <= cfg_data;
        CFG_PRESS_HI:  press_high  <= cfg_data;
        CFG_PRESS_P9:  press_nine  <= cfg_data[15:0];
        CFG_HUM:       hum_coeffs  <= cfg_data;
        default: ;
      endcase
    end
  end

  word_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  word_t h1, h2, h3, h4, h5, h6;
  assign t1 = {16'b0, temp_coeffs[15:0]};
  assign t2 = {{16{temp_coeffs[31]}}, temp_coeffs[31:16]};
  assign t3 = {{16{temp_coeffs[47]}}, temp_coeffs[47:32]};
  assign p1 = {16'b0, press_low[15:0]};
  assign p2 = {{16{press_low[31]}}, press_low[31:16]};
  assign p3 = {{16{press_low[47]}}, press_low[47:32]};
  assign p4 = {{16{press_low[63]}}, press_low[63:48]};
  assign p5 = {{16{press_high[15]}}, press_high[15:0]};
  assign p6 = {{16{press_high[31]}}, press_high[31:16]};
  assign p7 = {{16{press_high[47]}}, press_high[47:32]};
  assign p8 = {{16{press_high[63]}}, press_high[63:48]};
  assign p9 = {{16{press_nine[15]}}, press_nine};
  assign h1 = {24'b0, hum_coeffs[7:0]};
  assign h2 = {{16{hum_coeffs[23]}}, hum_coeffs[23:8]};
  assign h3 = {24'b0, hum_coeffs[31:24]};
  assign h4 = {{20{hum_coeffs[43]}}, hum_coeffs[43:32]};
  assign h5 = {{20{hum_coeffs[55]}}, hum_coeffs[55:44]};
  assign h6 = {{24{hum_coeffs[63]}}, hum_coeffs[63:56]};

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  logic        pre_vld [PRE];
  logic [19:0] p_pipe  [PRE-1];
  logic [15:0] h_pipe  [5];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PRE; i++) pre_vld[i] <= 1'b0;
    end else if (adv) begin
      pre_vld[0] <= in_valid;
      for (int i = 1; i < PRE; i++) pre_vld[i] <= pre_vld[i-1];
    end
    if (adv) begin
      p_pipe[0] <= raw_pressure;
      for (int i = 1; i < PRE-1; i++) p_pipe[i] <= p_pipe[i-1];
      h_pipe[0] <= raw_humidity;
      for (int i = 1; i < 5; i++) h_pipe[i] <= h_pipe[i-1];
    end
  end

  word_t adct, adcp, adch;
  assign adct = {12'b0, raw_temperature};
  assign adcp = {12'b0, p_pipe[PRE-2]};
  assign adch = {16'b0, h_pipe[4]};

  word_t s1_ta, s1_td, s2_am, s2_dd, s3_a, s3_b1, s4_fine;
  word_t s5_temp, s5_pa, s5_x0, s5_y1, s5_y2;
  word_t s6_temp, s6_pdd, s6_ap5, s6_ap2, s6_x, s6_ym;
  word_t s7_temp, s7_b6, s7_c3, s7_ap5, s7_ap2, s7_x, s7_yh;
  word_t s8_temp, s8_b, s8_a2, s8_hv;
  word_t s9_temp, s9_a3, s9_b, s9_hv, s9_hdd;
  word_t s10_temp, s10_div, s10_num, s10_hv, s10_e;

  word_t c5_fine, c5_v, c6_pd, c9_hd;

  always_comb begin
    c5_fine = s4_fine;
    c5_v    = c5_fine - 32'sd76800;
    c6_pd   = s5_pa >>> 2;
    c9_hd   = s8_hv >>> 15;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ta <= (adct >>> 3) - (t1 <<< 1);
      s1_td <= (adct >>> 4) - t1;
      s2_am <= s1_ta * t2;
      s2_dd <= s1_td * s1_td;
      s3_a  <= s2_am >>> 11;
      s3_b1 <= (s2_dd >>> 12) * t3;
      s4_fine <= s3_a + (s3_b1 >>> 14);
      // temperature, pressure start and humidity start
      s5_temp <= ((c5_fine <<< 2) + c5_fine + 32'sd128) >>> 8;
      s5_pa   <= (c5_fine >>> 1) - 32'sd64000;
      s5_x0   <= h5 * c5_v;
      s5_y1   <= c5_v * h6;
      s5_y2   <= c5_v * h3;
      s6_temp <= s5_temp;
      s6_pdd  <= c6_pd * c6_pd;
      s6_ap5  <= s5_pa * p5;
      s6_ap2  <= p2 * s5_pa;
      s6_x    <= ((adch <<< 14) - (h4 <<< 20) - s5_x0 + 32'sd16384) >>> 15;
      s6_ym   <= (s5_y1 >>> 10) * ((s5_y2 >>> 11) + 32'sd32768);
      s7_temp <= s6_temp;
      s7_b6   <= (s6_pdd >>> 11) * p6;
      s7_c3   <= p3 * (s6_pdd >>> 13);
      s7_ap5  <= s6_ap5;
      s7_ap2  <= s6_ap2;
      s7_x    <= s6_x;
      s7_yh   <= ((s6_ym >>> 10) + 32'sd2097152) * h2;
      s8_temp <= s7_temp;
      s8_b    <= ((s7_b6 + (s7_ap5 <<< 1)) >>> 2) + (p4 <<< 16);
      s8_a2   <= ((s7_c3 >>> 3) + (s7_ap2 >>> 1)) >>> 18;
      s8_hv   <= s7_x * ((s7_yh + 32'sd8192) >>> 14);
      s9_temp <= s8_temp;
      s9_a3   <= (32'sd32768 + s8_a2) * p1;
      s9_b    <= s8_b;
      s9_hv   <= s8_hv;
      s9_hdd  <= c9_hd * c9_hd;
      s10_temp <= s9_temp;
      s10_div  <= s9_a3 >>> 15;
      s10_num  <= ((32'sd1048576 - adcp) - (s9_b >>> 12)) * 32'sd3125;
      s10_hv   <= s9_hv;
      s10_e    <= (s9_hdd >>> 7) * h1;
    end
  end

  // divider feed and humidity clamp
  word_t       c11_hv;
  logic [31:0] c11_dividend;
  side_t       c11_side;
  always_comb begin
    c11_hv = s10_hv - (s10_e >>> 4);
    c11_side.temp      = s10_temp;
    c11_side.num_small = ~s10_num[31];
    c11_side.div_zero  = (s10_div == 32'sd0);
    if (c11_hv[31]) begin
      c11_side.hum = '0;
    end else if (c11_hv > HUM_MAX) begin
      c11_side.hum = HUM_MAX[28:12];
    end else begin
      c11_side.hum = c11_hv[28:12];
    end
    c11_dividend = c11_side.num_small ? {s10_num[30:0], 1'b0} : s10_num;
  end

  logic        dv_valid;
  logic [31:0] dv_quo;
  side_t       dv_side;

  pth_div #(.W(32), .SIDE_W($bits(side_t))) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (pre_vld[PRE-1]),
    .dividend  (c11_dividend),
    .divisor   (s10_div),
    .side_in   (c11_side),
    .out_valid (dv_valid),
    .quotient  (dv_quo),
    .side_out  (dv_side)
  );

  logic [31:0] c12_pres, c12_d;
  assign c12_pres = dv_side.num_small ? dv_quo : {dv_quo[30:0], 1'b0};
  assign c12_d    = c12_pres >> 3;

  logic        q1_vld, q2_vld;
  logic [31:0] q1_pres, q1_dd, q2_pres;
  word_t       q1_bb, q2_bb, q2_a, c14_sum;
  side_t       q1_side, q2_side;

  assign c14_sum = (q2_a >>> 12) + (q2_bb >>> 13) + p7;

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_vld    <= 1'b0;
      q2_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      q1_vld    <= dv_valid;
      q2_vld    <= q1_vld;
      out_valid <= q2_vld;
    end
    if (adv) begin
      q1_pres <= c12_pres;
      q1_dd   <= c12_d * c12_d;
      q1_bb   <= $signed(c12_pres >> 2) * p8;
      q1_side <= dv_side;
      q2_pres <= q1_pres;
      q2_a    <= p9 * $signed(q1_dd >> 13);
      q2_bb   <= q1_bb;
      q2_side <= q1_side;
      pressure_pa       <= q2_side.div_zero ? 32'd0 : q2_pres + $unsigned(c14_sum >>> 4);
      temperature_centi <= q2_side.temp;
      humidity_q10      <= q2_side.hum;
    end
  end

  `PTH_ASSERT_ALWAYS(a_stall_only_when_blocked, in_stall == (out_valid && out_stall),
    "input stalled without a blocked output")
  `PTH_ASSERT_ALWAYS(a_hum_range, !out_valid || (humidity_q10 <= 17'd102400),
    "humidity beyond full scale")
  `PTH_ASSERT_NEXT(a_div_to_post, dv_valid && !in_stall, q1_vld,
    "divider result lost on its way to refinement")
endmodule
`default_nettype wire
